@@ hw/rtl/sfd_pkg.sv @@
// Shared types and constants for the serial frame decoder.
// No dependencies; used by sfd_if, sfd_decode, sfd_out_stage and the top level.
`timescale 1ns / 1ps

package sfd_pkg;

  localparam logic [7:0] CONT_BIT   = 8'h80;
  localparam logic [7:0] EVENT_CHAR = 8'h5e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_LONG = 2'd1,
    STATUS_BAD_CMD  = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic        chan_flag;
    logic [4:0]  index;
    logic [31:0] value;
  } result_t;

endpackage

@@ hw/rtl/sfd_if.sv @@
// Handshake interfaces for received bytes and decoded results.
// Depends on sfd_pkg for the status type.
`timescale 1ns / 1ps

interface sfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_res_if;
  logic             valid;
  logic             ready;
  sfd_pkg::status_t status;
  logic             chan_flag;
  logic [4:0]       index;
  logic [31:0]      value;

  modport source (output valid, output status, output chan_flag, output index,
                  output value, input ready);
  modport sink   (input valid, input status, input chan_flag, input index,
                  input value, output ready);
endinterface

@@ hw/rtl/sfd_in_stage.sv @@
// Input register: holds one received byte until the decoder takes it.
// Depends on sfd_rx_if.
`timescale 1ns / 1ps

module sfd_in_stage (
  input  logic       clk,
  input  logic       rst,
  sfd_rx_if.sink     rx,
  input  logic       take,
  output logic       valid,
  output logic [7:0] rx_byte
);

  assign rx.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (rx.ready) begin
      valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      rx_byte <= rx.rx_byte;
    end
  end

endmodule

@@ hw/rtl/sfd_decode.sv @@
// Frame state and single-pass decode of one byte per cycle while take is high.
// Depends on sfd_pkg.
`timescale 1ns / 1ps

module sfd_decode #(
  parameter int MAX_FRAME_BYTES = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             take,
  input  logic [7:0]       rx_byte,
  output logic             emit,
  output sfd_pkg::result_t result
);

  localparam logic [2:0] MaxLen = 3'(MAX_FRAME_BYTES);

  logic        drop_event_char;
  logic [2:0]  byte_count;
  logic [31:0] accumulator;
  logic [2:0]  byte_count_next;
  logic [31:0] accumulator_next;
  logic [2:0]  length;
  logic [1:0]  sel;

  assign length = byte_count + 3'd1;
  assign sel    = rx_byte[6:5];

  always_comb begin
    emit              = 1'b0;
    result            = '0;
    result.status     = sfd_pkg::STATUS_OK;
    byte_count_next   = 3'd0;
    accumulator_next  = 32'd0;
    if ((rx_byte & sfd_pkg::CONT_BIT) != 8'd0) begin
      if (length < MaxLen) begin
        byte_count_next  = length;
        accumulator_next = {accumulator[24:0], rx_byte[6:0]};
      end else begin
        emit          = 1'b1;
        result.status = sfd_pkg::STATUS_TOO_LONG;
      end
    end else if (byte_count == 3'd0) begin
      // lone byte: digital value, dropped event char or bad command
      if (!sel[1]) begin
        emit         = 1'b1;
        result.index = rx_byte[4:0];
        result.value = {31'd0, sel[0]};
      end else if (!(rx_byte == sfd_pkg::EVENT_CHAR && drop_event_char)) begin
        emit          = 1'b1;
        result.status = sfd_pkg::STATUS_BAD_CMD;
      end
    end else begin
      emit             = 1'b1;
      result.chan_flag = 1'b1;
      result.index     = rx_byte[4:0];
      result.value     = {accumulator[29:0], sel};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_event_char <= 1'b1;
      byte_count      <= 3'd0;
      accumulator     <= 32'd0;
    end else begin
      if (cfg_we) begin
        drop_event_char <= cfg_wdata;
      end
      if (take) begin
        byte_count  <= byte_count_next;
        accumulator <= accumulator_next;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count < MaxLen)
    else $error("frame byte count out of range");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    take && emit |=> byte_count == 3'd0 && accumulator == 32'd0)
    else $error("parser not restarted after a result");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    emit && result.status != sfd_pkg::STATUS_OK |->
      !result.chan_flag && result.index == 5'd0 && result.value == 32'd0)
    else $error("error result carries payload");

  a_chan_ok: assert property (@(posedge clk) disable iff (rst)
    emit && result.chan_flag |-> result.status == sfd_pkg::STATUS_OK)
    else $error("channel result with error status");

endmodule

@@ hw/rtl/sfd_out_stage.sv @@
// Result register: holds one decoded result until the sink takes it.
// Depends on sfd_pkg and sfd_res_if.
`timescale 1ns / 1ps

module sfd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  sfd_pkg::result_t result,
  output logic             free,
  sfd_res_if.source        res
);

  sfd_pkg::result_t held;

  assign free          = !res.valid || res.ready;
  assign res.status    = held.status;
  assign res.chan_flag = held.chan_flag;
  assign res.index     = held.index;
  assign res.value     = held.value;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (free) begin
      res.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= result;
    end
  end

endmodule

@@ hw/rtl/serial_frame_decoder.sv @@
// Serial frame decoder top level.
// Depends on sfd_pkg, sfd_if, sfd_in_stage, sfd_decode and sfd_out_stage.
`timescale 1ns / 1ps

// Takes one received byte per clock cycle unless the result register is
// full, and gives at most one result per byte. A byte waits in the input
// register and is decoded into the result register, which offers the result on res.
// The rate is set by the frame state (byte count and 32-bit accumulator),
// which is updated once for every byte taken. A byte that produces no result
// (continuation or dropped event char) still passes the decode stage and
// waits in the input register while the result register is full.
// drop_event_char resets to 1 and is written through cfg_we/cfg_wdata.
module serial_frame_decoder #(
  parameter int MAX_FRAME_BYTES = 6
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  sfd_rx_if.sink    rx,
  sfd_res_if.source res
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             out_free;
  logic             take;
  logic             emit;
  sfd_pkg::result_t result;

  assign take = in_valid && out_free;

  sfd_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .take    (take),
    .valid   (in_valid),
    .rx_byte (in_byte)
  );

  sfd_decode #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .rx_byte   (in_byte),
    .emit      (emit),
    .result    (result)
  );

  sfd_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (take && emit),
    .result (result),
    .free   (out_free),
    .res    (res)
  );

endmodule
